FILE: sv/tsm_pkg.sv
// ============================================================================
// tsm_pkg: shared types and constants for the thermistor scan summarizer
// Holds the threshold ROM, the converted temperature table, word types and
// the sequencer's state and control types.
// ============================================================================
package tsm_pkg;

    // Threshold ROM geometry
    localparam int ROM_SIZE = 33;
    localparam int IDX_W    = 6;

    // Shared subtractor width
    localparam int SUB_W = 16;

    // Sequencer step counts
    localparam int SEARCH_STEPS = 6;
    localparam int DIV_STEPS    = 14;
    localparam int STEP_W       = 4;

    // Accumulator limits and checksum bias
    localparam logic [12:0] SUM_LIMIT   = 13'd4095;
    localparam logic [6:0]  COUNT_LIMIT = 7'd127;
    localparam logic [7:0]  CHECK_BIAS  = 8'hBE;
    localparam logic [7:0]  MIN_RESET   = 8'd100;
    localparam logic [7:0]  AVG_CLAMP   = 8'd127;

    // Mask register indexes
    localparam logic REG_MASK_LOW  = 1'b0;
    localparam logic REG_MASK_HIGH = 1'b1;

    localparam logic [31:0] MASK_LOW_RESET  = 32'hEF00003D;
    localparam logic [31:0] MASK_HIGH_RESET = 32'h0FFF7FFE;

    typedef struct packed {
        logic [15:0] sample;
        logic [5:0]  sensor_index;
        logic        scan_end;
    } tsm_in_t;

    typedef struct packed {
        logic signed [7:0] low_deg;
        logic signed [7:0] high_deg;
        logic signed [7:0] mean_deg;
        logic [7:0]        frame_checksum;
    } tsm_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_DIVIDE,
        ST_EMIT
    } tsm_state_t;

    // Sequencer strobes toward the datapath
    typedef struct packed {
        logic              in_ready;
        logic              load_item;
        logic              search_step;
        logic              update;
        logic              div_step;
        logic              emit;
        logic [STEP_W-1:0] step;
    } tsm_ctrl_t;

    // ADC code thresholds, falling; unused codes read as zero
    function automatic logic [15:0] thr_code(input logic [IDX_W-1:0] idx);
        logic [15:0] code;
        unique case (idx)
            6'd0:  code = 16'd48456;
            6'd1:  code = 16'd48059;
            6'd2:  code = 16'd47662;
            6'd3:  code = 16'd47265;
            6'd4:  code = 16'd46669;
            6'd5:  code = 16'd46073;
            6'd6:  code = 16'd45080;
            6'd7:  code = 16'd44286;
            6'd8:  code = 16'd43094;
            6'd9:  code = 16'd41903;
            6'd10: code = 16'd40711;
            6'd11: code = 16'd39520;
            6'd12: code = 16'd38130;
            6'd13: code = 16'd36938;
            6'd14: code = 16'd35746;
            6'd15: code = 16'd34555;
            6'd16: code = 16'd33363;
            6'd17: code = 16'd32370;
            6'd18: code = 16'd31576;
            6'd19: code = 16'd30782;
            6'd20: code = 16'd29987;
            6'd21: code = 16'd29391;
            6'd22: code = 16'd28796;
            6'd23: code = 16'd28398;
            6'd24: code = 16'd27803;
            6'd25: code = 16'd27405;
            6'd26: code = 16'd27207;
            6'd27: code = 16'd26810;
            6'd28: code = 16'd26611;
            6'd29: code = 16'd26412;
            6'd30: code = 16'd26214;
            6'd31: code = 16'd26015;
            6'd32: code = 16'd25817;
            default: code = 16'd0;
        endcase
        return code;
    endfunction

    // Table temperature already taken through (t-32)*5/9, truncated
    function automatic logic signed [7:0] conv_temp(input logic [IDX_W-1:0] idx);
        logic signed [7:0] temp;
        unique case (idx)
            6'd0:  temp = -8'sd40;
            6'd1:  temp = -8'sd37;
            6'd2:  temp = -8'sd34;
            6'd3:  temp = -8'sd31;
            6'd4:  temp = -8'sd28;
            6'd5:  temp = -8'sd26;
            6'd6:  temp = -8'sd23;
            6'd7:  temp = -8'sd20;
            6'd8:  temp = -8'sd17;
            6'd9:  temp = -8'sd15;
            6'd10: temp = -8'sd12;
            6'd11: temp = -8'sd9;
            6'd12: temp = -8'sd6;
            6'd13: temp = -8'sd3;
            6'd14: temp = -8'sd1;
            6'd15: temp = 8'sd1;
            6'd16: temp = 8'sd4;
            6'd17: temp = 8'sd7;
            6'd18: temp = 8'sd10;
            6'd19: temp = 8'sd12;
            6'd20: temp = 8'sd15;
            6'd21: temp = 8'sd18;
            6'd22: temp = 8'sd21;
            6'd23: temp = 8'sd23;
            6'd24: temp = 8'sd26;
            6'd25: temp = 8'sd29;
            6'd26: temp = 8'sd32;
            6'd27: temp = 8'sd35;
            6'd28: temp = 8'sd37;
            6'd29: temp = 8'sd40;
            6'd30: temp = 8'sd43;
            6'd31: temp = 8'sd46;
            6'd32: temp = 8'sd48;
            default: temp = -8'sd40;
        endcase
        return temp;
    endfunction

endpackage

FILE: sv/thermistor_scan_min_max_avg_core.sv
// ============================================================================
// thermistor_scan_min_max_avg_core: thermistor scan min, max and average
// Maps ADC codes to temperatures, tracks min and max across scans and
// emits a summary word with a rounded average at each scan end.
// ============================================================================
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one sample word: ADC code,
//   sensor index and scan_end mark. out channel (out_valid/out_ready/
//   out_data) gives one summary word per scan: min, max, rounded average
//   and frame checksum. cfg_we/cfg_index/cfg_data write the two sensor
//   enable masks; write them only while the block is idle.
//   Each word passes through the idle/accept state, 6 binary-search
//   steps through the threshold ROM on the shared subtractor, and the
//   update state. A scan_end word adds 14 division steps on the same
//   subtractor and then loads the output register in the emit state.
//   The block handles one word at a time and drops in_ready meanwhile.
//   If the receiver stalls, the summary sits in the output register and the
//   block keeps accepting samples; only the next scan end waits for it.
//   Reset restores the mask defaults, min 100, max 0 and clears the sum
//   and count; no clearing pass is needed.
// ============================================================================
module thermistor_scan_min_max_avg_core
    import tsm_pkg::*;
#(
    parameter int SENSOR_COUNT  = 64,
    parameter int TABLE_ENTRIES = 33
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tsm_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output tsm_out_t    out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    // Last searchable ROM entry
    localparam int MATCH_LAST =
        ((TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE) - 1;

    tsm_ctrl_t ctrl;

    logic [31:0]      mask_low_reg, mask_high_reg;
    logic [15:0]      sample_reg;
    logic [5:0]       idx_reg;
    logic             last_reg;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [7:0]       run_min_reg, run_min_next;
    logic [7:0]       run_max_reg, run_max_next;
    logic [11:0]      sum_reg, sum_next;
    logic [6:0]       count_reg, count_next;
    logic [13:0]      num_reg, num_next;
    logic [7:0]       rem_reg, rem_next;
    logic [7:0]       den_reg, den_next;
    logic             out_valid_reg, out_valid_next;
    tsm_out_t         out_data_reg, out_data_next;

    logic             out_free;
    logic [2:0]       bit_sel;
    logic [IDX_W-1:0] cand;
    logic             cand_ok;
    logic [SUB_W-1:0] sub_a, sub_b, sub_diff;
    logic             sub_borrow;
    logic [8:0]       trial;
    logic [IDX_W-1:0] match_idx;
    logic signed [7:0] temp;
    logic             enabled;
    logic [63:0]      mask_all;
    logic [5:0]       temp_u;
    logic [12:0]      sum_trial;
    logic [7:0]       avg_val, min_val, max_val;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = ctrl.in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last_reg),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // Search candidate: set one index bit per step, MSB first
    assign bit_sel = 3'(SEARCH_STEPS - 1) - ctrl.step[2:0];
    assign cand    = pos_reg | (IDX_W'(1) << bit_sel);
    assign cand_ok = (cand <= IDX_W'(MATCH_LAST));

    // Division trial remainder
    assign trial = {rem_reg, num_reg[13]};

    // Shared subtractor operands
    always_comb
    begin
        if (ctrl.div_step)
        begin
            sub_a = SUB_W'(trial);
            sub_b = SUB_W'(den_reg);
        end
        else
        begin
            sub_a = thr_code(cand);
            sub_b = sample_reg;
        end
    end

    tsm_sub u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    // Temperature of the matched entry; entry 0 when nothing matched
    assign match_idx = pos_reg + 1'b1;
    assign temp      = (match_idx <= IDX_W'(MATCH_LAST)) ? conv_temp(match_idx)
                                                          : conv_temp('0);
    assign mask_all  = {mask_high_reg, mask_low_reg};
    assign enabled   = (7'(idx_reg) < 7'(SENSOR_COUNT)) && mask_all[idx_reg];
    assign temp_u    = temp[5:0];
    assign sum_trial = {1'b0, sum_reg} + 13'(temp_u);

    // Summary values at scan end
    always_comb
    begin
        if (count_reg == '0)
        begin
            avg_val = '0;
            min_val = '0;
            max_val = '0;
        end
        else
        begin
            avg_val = (num_reg > 14'(AVG_CLAMP)) ? AVG_CLAMP : num_reg[7:0];
            min_val = run_min_reg;
            max_val = run_max_reg;
        end
    end

    // Datapath next values
    always_comb
    begin
        pos_next       = pos_reg;
        run_min_next   = run_min_reg;
        run_max_next   = run_max_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ctrl.load_item)
        begin
            pos_next = '0;
        end

        // Keep the candidate while its threshold is not below the sample
        if (ctrl.search_step && cand_ok && !sub_borrow)
        begin
            pos_next = cand;
        end

        if (ctrl.update)
        begin
            if (enabled && !temp[7])
            begin
                if (temp_u < run_min_reg[5:0] || run_min_reg[7:6] != 2'b00)
                begin
                    run_min_next = 8'(temp_u);
                end
                if (8'(temp_u) > run_max_reg)
                begin
                    run_max_next = 8'(temp_u);
                end
                if (count_reg < COUNT_LIMIT && sum_trial <= SUM_LIMIT)
                begin
                    sum_next   = sum_trial[11:0];
                    count_next = count_reg + 1'b1;
                end
            end
            // Rounded average: (2*sum + count) / (2*count)
            num_next = 14'({sum_next, 1'b0}) + 14'(count_next);
            den_next = {count_next, 1'b0};
            rem_next = '0;
        end

        // One restoring division step; quotient shifts into num
        if (ctrl.div_step)
        begin
            rem_next = sub_borrow ? trial[7:0] : sub_diff[7:0];
            num_next = {num_reg[12:0], !sub_borrow};
        end

        if (ctrl.emit)
        begin
            out_valid_next               = 1'b1;
            out_data_next.low_deg        = min_val;
            out_data_next.high_deg       = max_val;
            out_data_next.mean_deg       = avg_val;
            out_data_next.frame_checksum = min_val + max_val + avg_val + CHECK_BIAS;
            run_min_next                 = min_val;
            run_max_next                 = max_val;
            sum_next                     = '0;
            count_next                   = '0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_low_reg  <= MASK_LOW_RESET;
            mask_high_reg <= MASK_HIGH_RESET;
            run_min_reg   <= MIN_RESET;
            run_max_reg   <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_MASK_LOW)
            begin
                mask_low_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_MASK_HIGH)
            begin
                mask_high_reg <= cfg_data;
            end
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            sample_reg <= in_data.sample;
            idx_reg    <= in_data.sensor_index;
            last_reg   <= in_data.scan_end;
        end
        pos_reg      <= pos_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    // A nonzero sum always has counted readings behind it
    a_sum_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg != '0) |-> (count_reg != '0))
        else $error("scan sum nonzero with zero count");

    // A summary clears the accumulators
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |=> (sum_reg == '0 && count_reg == '0))
        else $error("accumulators not cleared after summary");

    // A summary never overwrites a word still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> (!out_valid_reg || out_ready))
        else $error("summary loaded over a pending word");

    // Running min stays within its reset ceiling
    a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_min_reg <= MIN_RESET)
        else $error("running min out of range");

    // Search position never passes the last searchable entry
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.update |-> (pos_reg <= IDX_W'(MATCH_LAST)))
        else $error("search position beyond table");
`endif

endmodule

FILE: sv/tsm_sub.sv
// ============================================================================
// tsm_sub: shared subtract and compare unit
// Gives a - b and the borrow; used by the table search and by the divider.
// ============================================================================
module tsm_sub
    import tsm_pkg::*;
(
    input  logic [SUB_W-1:0] a,
    input  logic [SUB_W-1:0] b,
    output logic [SUB_W-1:0] diff,
    output logic             borrow
);

    // borrow set when a < b
    always_comb
    begin
        {borrow, diff} = {1'b0, a} - {1'b0, b};
    end

endmodule

FILE: sv/tsm_ctrl.sv
// ============================================================================
// tsm_ctrl: sequencer for the scan summarizer
// Steps one word through the table search, the update and, at scan end,
// the bit-serial division and the result hand-off.
// ============================================================================
module tsm_ctrl
    import tsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      last,
    input  logic      out_free,
    output tsm_ctrl_t ctrl
);

    tsm_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // State and step registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state and strobes
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        ctrl             = '0;
        ctrl.step        = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load_item = 1'b1;
                    step_next      = '0;
                    state_next     = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                ctrl.search_step = 1'b1;
                if (step_reg == STEP_W'(SEARCH_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_UPDATE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_UPDATE:
            begin
                ctrl.update = 1'b1;
                step_next   = '0;
                state_next  = last ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                ctrl.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ctrl.emit  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench for the thermistor scan min/max/average core
// Drives sample words through valid/ready, predicts each scan summary with a
// behavioral temperature model, and compares summary words field by field.
// The run goes through several mask settings and idle/stall profiles.
// ============================================================================
module tb_top;
    import tsm_pkg::*;

    localparam int          SENSORS        = 64;
    localparam int          THR_COUNT      = 33;
    localparam int unsigned ACC_SUM_MAX    = 4095;
    localparam int unsigned ACC_COUNT_MAX  = 127;
    localparam int          CHECK_OFFSET   = 'hBE;
    localparam logic [31:0] DEF_MASK_LOW   = 32'hEF00003D;
    localparam logic [31:0] DEF_MASK_HIGH  = 32'h0FFF7FFE;
    // Settling margin after the last summary of a phase
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          LONG_HOLD      = 400;
    localparam int          QUIET_LIMIT    = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    tsm_in_t     in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    tsm_out_t    out_data;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_MASK_LOW;
    logic [31:0] cfg_data = '0;

    // ADC thresholds of the table voltages, falling; entry e is -40F + 5F*e
    logic [15:0] adc_threshold [0:THR_COUNT-1] = '{
        16'd48456, 16'd48059, 16'd47662, 16'd47265, 16'd46669, 16'd46073,
        16'd45080, 16'd44286, 16'd43094, 16'd41903, 16'd40711, 16'd39520,
        16'd38130, 16'd36938, 16'd35746, 16'd34555, 16'd33363, 16'd32370,
        16'd31576, 16'd30782, 16'd29987, 16'd29391, 16'd28796, 16'd28398,
        16'd27803, 16'd27405, 16'd27207, 16'd26810, 16'd26611, 16'd26412,
        16'd26214, 16'd26015, 16'd25817
    };

    // Predictor state
    logic [31:0] mask_low  = DEF_MASK_LOW;
    logic [31:0] mask_high = DEF_MASK_HIGH;
    int          run_min   = 100;
    int          run_max   = 0;
    int unsigned acc_sum   = 0;
    int unsigned acc_count = 0;

    tsm_in_t  pending_words [$];
    tsm_out_t summary_expect [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_armed     = 1'b0;
    bit hold_used      = 1'b0;
    int hold_left      = 0;
    int errors         = 0;
    int quiet_cycles   = 0;

    thermistor_scan_min_max_avg_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Temperature model
    // ------------------------------------------------------------------
    // First threshold strictly below the code wins; none means -40F
    function automatic int adc_to_celsius(input logic [15:0] code);
        int  fahr;
        bit  hit;
        fahr = -40;
        hit  = 1'b0;
        for (int e = 1; e < THR_COUNT; e++)
        begin
            if (!hit && adc_threshold[e] < code)
            begin
                fahr = -40 + 5 * e;
                hit  = 1'b1;
            end
        end
        return ((fahr - 32) * 5) / 9;
    endfunction

    function automatic bit sensor_on(input logic [5:0] idx);
        logic [63:0] en;
        en = {mask_high, mask_low};
        return (idx < SENSORS) && en[idx];
    endfunction

    // Update running state for one accepted word; queue a summary on scan end
    function automatic void predict_word(input tsm_in_t w);
        int       deg;
        int       avg;
        tsm_out_t s;
        if (sensor_on(w.sensor_index))
        begin
            deg = adc_to_celsius(w.sample);
            if (deg >= 0)
            begin
                if (deg < run_min)
                    run_min = deg;
                if (deg > run_max)
                    run_max = deg;
                if (acc_count < ACC_COUNT_MAX && acc_sum + deg <= ACC_SUM_MAX)
                begin
                    acc_sum   = acc_sum + deg;
                    acc_count = acc_count + 1;
                end
            end
        end
        if (w.scan_end)
        begin
            if (acc_count == 0)
            begin
                run_min = 0;
                run_max = 0;
                avg     = 0;
            end
            else
                avg = (2 * acc_sum + acc_count) / (2 * acc_count);
            if (avg > 127)
                avg = 127;
            s.low_deg        = run_min[7:0];
            s.high_deg       = run_max[7:0];
            s.mean_deg       = avg[7:0];
            s.frame_checksum = 8'((run_min + run_max + avg + CHECK_OFFSET) & 'hFF);
            summary_expect.push_back(s);
            acc_sum   = 0;
            acc_count = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_word(input logic [15:0] s, input logic [5:0] idx,
                                      input logic last);
        tsm_in_t w;
        w.sample       = s;
        w.sensor_index = idx;
        w.scan_end     = last;
        pending_words.push_back(w);
    endfunction

    // Code that maps to a non-negative temperature, boundaries favored
    function automatic logic [15:0] warm_sample();
        int          e;
        int unsigned lo;
        int unsigned hi;
        logic [15:0] s;
        e  = $urandom_range(32, 15);
        lo = adc_threshold[e] + 1;
        hi = adc_threshold[e-1];
        case ($urandom_range(3, 0))
            0:       s = lo[15:0];
            1:       s = hi[15:0];
            default: s = 16'($urandom_range(hi, lo));
        endcase
        return s;
    endfunction

    // Code that maps below zero or misses the table
    function automatic logic [15:0] cold_sample();
        logic [15:0] s;
        if ($urandom_range(1, 0) == 0)
            s = 16'($urandom_range(65535, 35747));
        else
            s = 16'($urandom_range(25817, 0));
        return s;
    endfunction

    function automatic logic [5:0] enabled_sensor();
        logic [5:0] idx;
        idx = 6'($urandom_range(63, 0));
        for (int k = 0; k < 16; k++)
        begin
            if (!sensor_on(idx))
                idx = 6'($urandom_range(63, 0));
        end
        return idx;
    endfunction

    // Mixed scans: mostly counted readings, some noise, some empty scans
    function automatic void queue_random_scans(input int n_words);
        int added;
        int len;
        int kind;
        bit empty_scan;
        logic [15:0] s;
        logic [5:0]  idx;
        added = 0;
        while (added < n_words)
        begin
            len        = ($urandom_range(9, 0) == 0) ? 1 : $urandom_range(12, 2);
            empty_scan = ($urandom_range(11, 0) == 0);
            for (int k = 0; k < len; k++)
            begin
                kind = $urandom_range(99, 0);
                if (empty_scan)
                begin
                    s   = cold_sample();
                    idx = 6'($urandom_range(63, 0));
                end
                else if (kind < 70)
                begin
                    s   = warm_sample();
                    idx = enabled_sensor();
                end
                else if (kind < 80)
                begin
                    s   = 16'($urandom_range(65535, 0));
                    idx = enabled_sensor();
                end
                else if (kind < 90)
                begin
                    s   = warm_sample();
                    idx = 6'($urandom_range(63, 0));
                end
                else
                begin
                    s   = 16'($urandom_range(65535, 0));
                    idx = 6'($urandom_range(63, 0));
                end
                push_word(s, idx, k == len - 1);
            end
            added = added + len;
        end
    endfunction

    // One long scan of readings all in one band
    function automatic void queue_long_scan(input int len, input logic [15:0] lo,
                                            input logic [15:0] hi);
        for (int k = 0; k < len; k++)
            push_word(16'($urandom_range(hi, lo)), enabled_sensor(), k == len - 1);
    endfunction

    // Both masks, back to back
    task automatic write_masks(input logic [31:0] low_val, input logic [31:0] high_val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MASK_LOW;
        cfg_data  <= low_val;
        @(posedge clk);
        cfg_index <= REG_MASK_HIGH;
        cfg_data  <= high_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mask_low  = low_val;
        mask_high = high_val;
    endtask

    // Wait until every word is in and every summary is out
    task automatic drain();
        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (summary_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_words.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output ready: random stalls, one long hold-off when armed
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (hold_armed && !hold_used && out_valid)
            begin
                hold_left = LONG_HOLD;
                hold_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitors: predict on accepted sample words, check summary words
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            predict_word(in_data);
    end

    always @(posedge clk)
    begin
        tsm_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (summary_expect.size() == 0)
            begin
                $error("unexpected summary word min=%0d max=%0d avg=%0d sum=%0h",
                       out_data.low_deg, out_data.high_deg, out_data.mean_deg,
                       out_data.frame_checksum);
                errors = errors + 1;
            end
            else
            begin
                want = summary_expect.pop_front();
                if (out_data.low_deg !== want.low_deg)
                begin
                    $error("low_deg expected %0d got %0d", want.low_deg, out_data.low_deg);
                    errors = errors + 1;
                end
                if (out_data.high_deg !== want.high_deg)
                begin
                    $error("high_deg expected %0d got %0d", want.high_deg, out_data.high_deg);
                    errors = errors + 1;
                end
                if (out_data.mean_deg !== want.mean_deg)
                begin
                    $error("mean_deg expected %0d got %0d", want.mean_deg, out_data.mean_deg);
                    errors = errors + 1;
                end
                if (out_data.frame_checksum !== want.frame_checksum)
                begin
                    $error("frame_checksum expected %0h got %0h",
                           want.frame_checksum, out_data.frame_checksum);
                    errors = errors + 1;
                end
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL thermistor_scan_min_max_avg_core");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under reset masks, no idling
        push_word(16'd30000, 6'd1,  1'b1);   // empty scan right after reset
        push_word(16'd0,     6'd0,  1'b0);   // below every threshold
        push_word(16'd65535, 6'd0,  1'b0);   // coldest matched entry
        push_word(16'd25817, 6'd0,  1'b0);   // equal to last threshold: no match
        push_word(16'd25818, 6'd0,  1'b0);   // hottest entry
        push_word(16'd35746, 6'd2,  1'b0);   // first non-negative entry
        push_word(16'd35747, 6'd3,  1'b0);   // just below zero
        push_word(16'd30000, 6'd63, 1'b0);   // masked top sensor
        push_word(16'd30000, 6'd32, 1'b0);   // masked
        push_word(16'd30000, 6'd33, 1'b1);
        push_word(16'd26015, 6'd0,  1'b1);   // equal to threshold, next entry wins
        push_word(16'd30000, 6'd1,  1'b1);   // empty scan after counted ones
        push_word(16'd35000, 6'd0,  1'b0);   // 1 and 4 average to a half
        push_word(16'd34000, 6'd2,  1'b1);
        push_word(16'd65535, 6'd63, 1'b0);
        push_word(16'd0,     6'd0,  1'b1);
        drain();

        // All sensors on, sender idling
        write_masks(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_idle_pct = 46;
        queue_random_scans(180);
        drain();

        // All sensors off, receiver stalling
        write_masks(32'h00000000, 32'h00000000);
        send_idle_pct  = 0;
        recv_stall_pct = 46;
        queue_random_scans(60);
        drain();

        // Random masks, light idling on both sides, accumulator limits
        write_masks($urandom | 32'h1, $urandom);
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        queue_random_scans(100);
        queue_long_scan(130, 16'd34556, 16'd35746);   // count limit at temp 1
        queue_random_scans(50);
        queue_long_scan(95, 16'd25818, 16'd26015);    // sum limit at temp 48
        queue_random_scans(50);
        drain();

        // Alternating masks, long receiver hold-off while words keep coming
        write_masks(32'hAAAAAAAA, 32'h55555555);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_armed     = 1'b1;
        queue_random_scans(150);
        drain();

        // Back to reset masks, receiver stalling
        write_masks(DEF_MASK_LOW, DEF_MASK_HIGH);
        recv_stall_pct = 46;
        queue_random_scans(130);
        drain();

        if (errors == 0)
            $display("PASS thermistor_scan_min_max_avg_core");
        else
            $display("FAIL thermistor_scan_min_max_avg_core");
        $finish;
    end

endmodule
